/* rtl/core/xte_pkg.sv */
// ----------------------------------------------------------------------------
// xte_pkg
// Shared types, character codes and escape tables of the XML text escaper.
// ----------------------------------------------------------------------------
package xte_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RUN     = 5;
    localparam int IDX_W       = $clog2(MAX_RUN);

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_BQ   = 8'h60;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_F    = 8'h66;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_T    = 8'h74;

    typedef enum logic [2:0] {
        KIND_SINGLE,
        KIND_LT,
        KIND_AMP,
        KIND_GT,
        KIND_NL,
        KIND_LF
    } run_kind_t;

    typedef struct packed {
        run_kind_t  kind;
        logic [7:0] ch;
    } item_t;

    function automatic logic [IDX_W-1:0] run_len_m1(input run_kind_t kind);
        logic [IDX_W-1:0] n;
        case (kind)
            KIND_SINGLE: n = IDX_W'(0);
            KIND_AMP:    n = IDX_W'(4);
            KIND_LT,
            KIND_GT,
            KIND_NL,
            KIND_LF:     n = IDX_W'(3);
            default:     n = IDX_W'(0);
        endcase
        return n;
    endfunction

    function automatic logic [7:0] esc_byte(input run_kind_t kind,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [7:0] ch);
        logic [7:0] b;
        logic [7:0] mid1;
        logic [7:0] mid2;
        case (kind)
            KIND_LT:  begin mid1 = CH_L; mid2 = CH_T; end
            KIND_GT:  begin mid1 = CH_G; mid2 = CH_T; end
            KIND_NL:  begin mid1 = CH_N; mid2 = CH_L; end
            KIND_LF:  begin mid1 = CH_L; mid2 = CH_F; end
            default:  begin mid1 = CH_A; mid2 = CH_M; end
        endcase
        if (kind == KIND_SINGLE)
        begin
            b = ch;
        end
        else
        begin
            case (idx)
                IDX_W'(0): b = CH_AMP;
                IDX_W'(1): b = mid1;
                IDX_W'(2): b = mid2;
                IDX_W'(3): b = (kind == KIND_AMP) ? CH_P : CH_SEMI;
                default:   b = CH_SEMI;
            endcase
        end
        return b;
    endfunction

endpackage

/* rtl/core/xml_text_escaper.sv */
// ----------------------------------------------------------------------------
// xml_text_escaper
// Escapes text characters into XML entity runs, tracking quoted spans.
// ----------------------------------------------------------------------------
//  channel  | ports                       | accepted when
//  ---------+-----------------------------+-----------------------
//  input    | command, text_char          | push && !full
//  result   | out_byte, last_byte         | pop && !empty
//
//  One input beat is taken per cycle while the queue has room.
//  Results leave at one byte per cycle from the output register while
//  pop is held and items wait; an item's run has 1, 4 or 5 bytes.
//  Reset clears the quote state, the queue and the output register.
//  A stalled result side fills the queue, then raises full.
// ----------------------------------------------------------------------------
module xml_text_escaper
#(
    parameter int QUEUE_DEPTH = xte_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       command,
    input  logic [7:0] text_char,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_byte
);

    xte_pkg::item_t wr_item;
    xte_pkg::item_t rd_item;
    logic           q_wr;
    logic           q_rd;
    logic           q_full;
    logic           q_empty;

    assign full = q_full;

    xte_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .command   (command),
        .text_char (text_char),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_data    (wr_item)
    );

    xte_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (wr_item),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (rd_item),
        .empty   (q_empty)
    );

    xte_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (rd_item),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule

/* rtl/core/xte_front.sv */
// ----------------------------------------------------------------------------
// xte_front
// Accepts input beats, classifies each into an escape run and tracks the
// quoted span state.
// ----------------------------------------------------------------------------
module xte_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic            command,
    input  logic [7:0]      text_char,
    input  logic            q_full,
    output logic            q_wr,
    output xte_pkg::item_t  q_data
);

    logic       in_quote_reg;
    logic       in_quote_next;
    logic [7:0] open_quote_reg;
    logic [7:0] open_quote_next;
    logic       accept;
    logic       is_quote;

    assign accept   = push && !q_full;
    assign q_wr     = accept;
    assign is_quote = (text_char == xte_pkg::CH_DQ) || (text_char == xte_pkg::CH_SQ)
                   || (text_char == xte_pkg::CH_BQ);

    always_comb
    begin
        in_quote_next   = in_quote_reg;
        open_quote_next = open_quote_reg;
        q_data.kind     = xte_pkg::KIND_SINGLE;
        q_data.ch       = text_char;
        if (command == xte_pkg::CMD_EOL)
        begin
            q_data.ch       = xte_pkg::CH_NL;
            in_quote_next   = 1'b0;
            open_quote_next = 8'h00;
        end
        else if (text_char == xte_pkg::CH_LT)
        begin
            q_data.kind = xte_pkg::KIND_LT;
        end
        else if (text_char == xte_pkg::CH_AMP)
        begin
            q_data.kind = xte_pkg::KIND_AMP;
        end
        else if (text_char == xte_pkg::CH_GT)
        begin
            q_data.kind = xte_pkg::KIND_GT;
        end
        else if (is_quote)
        begin
            if (in_quote_reg)
            begin
                if (open_quote_reg == text_char)
                begin
                    in_quote_next = 1'b0;
                end
            end
            else
            begin
                in_quote_next   = 1'b1;
                open_quote_next = text_char;
            end
        end
        else if (in_quote_reg && (text_char == xte_pkg::CH_NL))
        begin
            q_data.kind = xte_pkg::KIND_NL;
        end
        else if (in_quote_reg && (text_char == xte_pkg::CH_CR))
        begin
            q_data.kind = xte_pkg::KIND_LF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quote_reg   <= 1'b0;
            open_quote_reg <= 8'h00;
        end
        else if (accept)
        begin
            in_quote_reg   <= in_quote_next;
            open_quote_reg <= open_quote_next;
        end
    end

endmodule

/* rtl/core/xte_queue.sv */
// ----------------------------------------------------------------------------
// xte_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module xte_queue
#(
    parameter int DEPTH = xte_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  xte_pkg::item_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output xte_pkg::item_t  rd_data,
    output logic            empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    xte_pkg::item_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == CNT_W'(0));
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/xte_back.sv */
// ----------------------------------------------------------------------------
// xte_back
// Expands the item at the head of the queue into its byte run, one output
// beat per cycle while pop is held, through an output register.
// ----------------------------------------------------------------------------
module xte_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  xte_pkg::item_t            q_data,
    output logic                      q_rd,
    output logic                      empty,
    input  logic                      pop,
    output logic [7:0]                out_byte,
    output logic                      last_byte
);

    logic                     valid_reg;
    logic [7:0]               byte_reg;
    logic                     last_reg;
    logic [xte_pkg::IDX_W-1:0] idx_reg;
    logic                     slot_free;
    logic                     load;
    logic                     at_last;

    assign slot_free = !valid_reg || pop;
    assign load      = slot_free && !q_empty;
    assign at_last   = (idx_reg == xte_pkg::run_len_m1(q_data.kind));
    assign q_rd      = load && at_last;

    assign empty     = !valid_reg;
    assign out_byte  = byte_reg;
    assign last_byte = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= xte_pkg::esc_byte(q_data.kind, idx_reg, q_data.ch);
            last_reg <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_last ? '0 : idx_reg + 1'b1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the XML text escaper. Characters and end-of-line
// commands go in through the push/full queue side. A scoreboard predicts the
// escaped byte runs and the quoted-span state, and checks every popped beat
// in order. Both sides idle in random bursts, and the result side holds off
// once for a long stretch so that the block fills up and raises full.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TOTAL_ITEMS   = 420;
    localparam int HOLD_AT_ITEM  = 150;
    localparam int QUIET_AT_ITEM = 340;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 30;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } out_beat_t;

    class escape_scoreboard;
        bit         in_span;
        logic [7:0] span_quote;
        out_beat_t  expected_beats[$];
        int         mismatches;

        function new();
            in_span    = 1'b0;
            span_quote = 8'h00;
            mismatches = 0;
        endfunction

        function void add_beat(logic [7:0] value, logic last);
            out_beat_t b;
            b.value = value;
            b.last  = last;
            expected_beats.push_back(b);
        endfunction

        function void note_char(logic cmd, logic [7:0] ch);
            string run;
            run = "";
            if (cmd == xte_pkg::CMD_EOL)
            begin
                in_span    = 1'b0;
                span_quote = 8'h00;
                add_beat(xte_pkg::CH_NL, 1'b1);
                return;
            end
            case (ch)
                xte_pkg::CH_LT:  run = "&lt;";
                xte_pkg::CH_AMP: run = "&amp;";
                xte_pkg::CH_GT:  run = "&gt;";
                xte_pkg::CH_DQ, xte_pkg::CH_SQ, xte_pkg::CH_BQ:
                begin
                    if (in_span)
                    begin
                        if (span_quote == ch)
                            in_span = 1'b0;
                    end
                    else
                    begin
                        in_span    = 1'b1;
                        span_quote = ch;
                    end
                end
                xte_pkg::CH_NL:  if (in_span) run = "&nl;";
                xte_pkg::CH_CR:  if (in_span) run = "&lf;";
                default: ;
            endcase
            if (run.len() == 0)
                add_beat(ch, 1'b1);
            else
                for (int i = 0; i < run.len(); i++)
                    add_beat(run[i], i == run.len() - 1);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 40)
                $display("%0t ns mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_beat(logic [7:0] value, logic last);
            out_beat_t exp;
            if (expected_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat out_byte=%02h last_byte=%0b",
                                          value, last));
                return;
            end
            exp = expected_beats.pop_front();
            if (value !== exp.value)
                report_mismatch($sformatf("out_byte %02h, want %02h", value, exp.value));
            if (last !== exp.last)
                report_mismatch($sformatf("last_byte %0b, want %0b on byte %02h",
                                          last, exp.last, exp.value));
        endtask

        task drain_check();
            if (expected_beats.size() != 0)
                report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));
        endtask
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       command   = xte_pkg::CMD_TEXT;
    logic [7:0] text_char = 8'h00;
    logic       pop       = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       last_byte;

    escape_scoreboard sb = new();
    int         items_sent   = 0;
    bit         quiet        = 1'b0;
    bit         hold_request = 1'b0;
    logic [7:0] special_chars [8] = '{xte_pkg::CH_LT, xte_pkg::CH_AMP, xte_pkg::CH_GT,
                                      xte_pkg::CH_DQ, xte_pkg::CH_SQ, xte_pkg::CH_BQ,
                                      xte_pkg::CH_NL, xte_pkg::CH_CR};
    logic [7:0] quote_chars   [3] = '{xte_pkg::CH_DQ, xte_pkg::CH_SQ, xte_pkg::CH_BQ};

    xml_text_escaper dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .text_char (text_char),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 9) < 4)
            return special_chars[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(logic cmd, logic [7:0] ch);
        int gap;
        push      <= 1'b1;
        command   <= cmd;
        text_char <= ch;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_char(cmd, ch);
        items_sent++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            push      <= 1'b0;
            text_char <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(logic [7:0] ch);
        send_item(xte_pkg::CMD_TEXT, ch);
    endtask

    // result side: check each popped beat, stall in bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_beat(out_byte, last_byte);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        logic [7:0] q;
        int         n;
        bit         hold_done;
        hold_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text(8'h00);
        send_text(8'hFF);
        send_text(8'h41);
        send_text(xte_pkg::CH_LT);
        send_text(xte_pkg::CH_AMP);
        send_text(xte_pkg::CH_GT);
        send_text(xte_pkg::CH_NL);
        send_text(xte_pkg::CH_CR);
        send_text(xte_pkg::CH_DQ);
        send_text(xte_pkg::CH_NL);
        send_text(xte_pkg::CH_CR);
        send_text(xte_pkg::CH_SQ);
        send_text(xte_pkg::CH_BQ);
        send_text(xte_pkg::CH_DQ);
        send_text(xte_pkg::CH_SQ);
        send_text(xte_pkg::CH_DQ);
        send_text(xte_pkg::CH_SQ);
        send_text(xte_pkg::CH_BQ);
        send_text(xte_pkg::CH_NL);
        send_item(xte_pkg::CMD_EOL, 8'hFF);
        send_text(xte_pkg::CH_NL);
        send_item(xte_pkg::CMD_EOL, 8'h00);
        send_text(xte_pkg::CH_CR);

        while (items_sent < TOTAL_ITEMS)
        begin
            if (!hold_done && items_sent >= HOLD_AT_ITEM)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (items_sent >= QUIET_AT_ITEM)
                quiet = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    q = quote_chars[$urandom_range(0, 2)];
                    send_text(q);
                    n = $urandom_range(0, 8);
                    repeat (n) send_text(pick_char());
                    if ($urandom_range(0, 4) != 0)
                        send_text(q);
                end
                6, 7:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_text(pick_char());
                end
                8:       send_item(xte_pkg::CMD_EOL, 8'($urandom_range(0, 255)));
                default: send_text(8'($urandom_range(0, 255)));
            endcase
        end
        push <= 1'b0;

        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.drain_check();
        if (sb.mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* xml_text_escaper.f */
rtl/core/xte_pkg.sv
rtl/core/xte_front.sv
rtl/core/xte_queue.sv
rtl/core/xte_back.sv
rtl/core/xml_text_escaper.sv
verif/tb_top.sv
